/* hw/rtl/brbp_pkg.sv */
package brbp_pkg;

  // Row geometry and field widths
  localparam int ROW_LEN    = 64;
  localparam int VAR_BITS   = 12;
  localparam int IN_VAR_W   = 12;
  localparam int VAR_W      = (VAR_BITS < IN_VAR_W) ? VAR_BITS : IN_VAR_W;
  localparam int COEF_W     = 32;
  localparam int TOL_W      = 16;
  localparam int IDX_W      = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int CNT_W      = $clog2(ROW_LEN + 1);
  // activity sum of ROW_LEN Q16.16 terms
  localparam int ACT_W      = COEF_W + IDX_W + 1;
  // slack and slack plus tolerance
  localparam int JW         = ACT_W + 3;
  // two banks, selected by the top address bit
  localparam int ADDR_W     = IDX_W + 1;

  // Stream packing
  localparam int IN_TDATA_W  = 80;
  localparam int IN_COEF_LO  = IN_VAR_W;
  localparam int IN_LO_BIT   = IN_COEF_LO + COEF_W;
  localparam int IN_UP_BIT   = IN_LO_BIT + 1;
  localparam int IN_RHS_LO   = IN_UP_BIT + 1;
  localparam int OUT_VAR_W   = 12;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    VERD_FIX0     = 2'd0,
    VERD_FIX1     = 2'd1,
    VERD_NONE     = 2'd2,
    VERD_CONFLICT = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [VAR_W-1:0]  var_idx;
    logic [COEF_W-1:0] coef;
    logic              fixed;
    logic              value;
  } elem_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    elem_t             data;
  } mem_wr_t;

  // One finished row handed from the loader to the walker
  typedef struct packed {
    logic              bank;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  unf;
    logic [ACT_W-1:0]  act;
    logic [COEF_W-1:0] rhs;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ROW,
    BK_OUT_RD,
    BK_OUT_CHK,
    BK_SCAN_RD,
    BK_SCAN_CHK,
    BK_CALC,
    BK_JUDGE,
    BK_DONE
  } back_state_t;

  // Minimum contribution of one element to the row activity
  function automatic logic signed [ACT_W-1:0] contrib(
    input logic signed [COEF_W-1:0] coef,
    input logic                     fixed,
    input logic                     value
  );
    logic signed [ACT_W-1:0] r;
    r = '0;
    if (fixed) begin
      if (value) r = ACT_W'(coef);
    end else if (coef[COEF_W-1]) begin
      r = ACT_W'(coef);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/brbp_front.sv */
module brbp_front
  import brbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic                  job_full,
  output logic                  job_push,
  output job_t                  job,
  output mem_wr_t               wr
);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        unf_r, unf_nxt;
  logic signed [ACT_W-1:0] act_r, act_nxt;
  logic                    bank_r;
  logic                    accept, store, lo, up;
  logic signed [COEF_W-1:0] coef, rhs;
  logic [IN_VAR_W-1:0]     var_in;

  // Field unpacking
  assign var_in = in_tdata[IN_VAR_W-1:0];
  assign coef   = $signed(in_tdata[IN_COEF_LO +: COEF_W]);
  assign lo     = in_tdata[IN_LO_BIT];
  assign up     = in_tdata[IN_UP_BIT];
  assign rhs    = $signed(in_tdata[IN_RHS_LO +: COEF_W]);

  // Stall only when both banks are owned by queued rows
  assign in_tready = !job_full;
  assign accept    = in_tvalid && in_tready;
  assign store     = accept && (cnt_r < CNT_W'(ROW_LEN));

  // Element store and running row sums
  always_comb begin
    cnt_nxt = cnt_r;
    unf_nxt = unf_r;
    act_nxt = act_r;
    if (store) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      act_nxt = act_r + contrib(coef, lo == up, lo);
      if (lo != up) unf_nxt = unf_r + CNT_W'(1);
    end
    wr.en           = store;
    wr.addr         = {bank_r, cnt_r[IDX_W-1:0]};
    wr.data.var_idx = var_in[VAR_W-1:0];
    wr.data.coef    = coef;
    wr.data.fixed   = (lo == up);
    wr.data.value   = lo;
    job_push        = accept && in_tlast;
    job.bank        = bank_r;
    job.cnt         = cnt_nxt;
    job.unf         = unf_nxt;
    job.act         = act_nxt;
    job.rhs         = rhs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      unf_r  <= '0;
      act_r  <= '0;
      bank_r <= 1'b0;
    end else if (job_push) begin
      cnt_r  <= '0;
      unf_r  <= '0;
      act_r  <= '0;
      bank_r <= !bank_r;
    end else begin
      cnt_r <= cnt_nxt;
      unf_r <= unf_nxt;
      act_r <= act_nxt;
    end
  end

endmodule

/* hw/rtl/brbp_job_fifo.sv */
module brbp_job_fifo
  import brbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic head_valid,
  output job_t head,
  output logic full
);

  // Two entries, one per memory bank; an entry is freed when its row is done
  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head_valid = (cnt_r != 2'd0);
  assign full       = (cnt_r == 2'd2);
  assign head       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* hw/rtl/brbp_back.sv */
module brbp_back
  import brbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  mem_wr_t                wr,
  input  logic                   job_valid,
  input  job_t                   job,
  output logic                   job_pop,
  input  logic [TOL_W-1:0]       tol,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] out_var_index, [13:12] verdict
  output logic                   out_tuser,  // [0] row_verdict
  output logic                   out_tlast
);

  // Element memory, two banks
  elem_t mem [2**ADDR_W];
  elem_t rd_q;
  logic [ADDR_W-1:0] rd_addr;

  back_state_t state_r, state_nxt;

  logic [IDX_W-1:0]         i_r, k_r;
  logic [CNT_W-1:0]         em_r;
  logic [VAR_W-1:0]         cur_var_r;
  logic signed [ACT_W-1:0]  excl_r;
  logic signed [COEF_W-1:0] coef_sel_r;
  logic                     found_r;
  logic signed [JW-1:0]     u_r;

  logic                     out_valid_r;
  logic [VAR_W-1:0]         out_var_r;
  verdict_t                 out_verd_r;
  logic                     out_row_r;
  logic                     out_last_r;

  logic slot_free, last_i, last_k;
  logic rd_sel_k, do_load_cur, do_scan, do_calc, do_emit, do_row, i_clr, i_inc;

  logic signed [JW-1:0] lim, coef_x;
  verdict_t             verd;
  logic                 row_conflict;

  assign slot_free = !out_valid_r || out_tready;
  assign last_i    = (CNT_W'(i_r) + CNT_W'(1)) == job.cnt;
  assign last_k    = (CNT_W'(k_r) + CNT_W'(1)) == job.cnt;

  // Memory: write from the loader, registered read for the walker
  assign rd_addr = {job.bank, rd_sel_k ? k_r : i_r};

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_q <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:     if (job_valid) state_nxt = (job.unf == '0) ? BK_ROW : BK_OUT_RD;
      BK_ROW:      if (slot_free) state_nxt = BK_DONE;
      BK_OUT_RD:   state_nxt = BK_OUT_CHK;
      BK_OUT_CHK: begin
        if (!rd_q.fixed)  state_nxt = BK_SCAN_RD;
        else if (last_i)  state_nxt = BK_DONE;
        else              state_nxt = BK_OUT_RD;
      end
      BK_SCAN_RD:  state_nxt = BK_SCAN_CHK;
      BK_SCAN_CHK: state_nxt = last_k ? BK_CALC : BK_SCAN_RD;
      BK_CALC:     state_nxt = BK_JUDGE;
      BK_JUDGE:    if (slot_free) state_nxt = last_i ? BK_DONE : BK_OUT_RD;
      BK_DONE:     state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    rd_sel_k    = 1'b0;
    do_load_cur = 1'b0;
    do_scan     = 1'b0;
    do_calc     = 1'b0;
    do_emit     = 1'b0;
    do_row      = 1'b0;
    i_clr       = 1'b0;
    i_inc       = 1'b0;
    job_pop     = 1'b0;
    case (state_r)
      BK_IDLE:     i_clr = 1'b1;
      BK_ROW:      do_row = slot_free;
      BK_OUT_CHK: begin
        do_load_cur = !rd_q.fixed;
        i_inc       = rd_q.fixed && !last_i;
      end
      BK_SCAN_RD:  rd_sel_k = 1'b1;
      BK_SCAN_CHK: do_scan = 1'b1;
      BK_CALC:     do_calc = 1'b1;
      BK_JUDGE: begin
        do_emit = slot_free;
        i_inc   = slot_free && !last_i;
      end
      BK_DONE:     job_pop = 1'b1;
      default:     ;
    endcase
  end

  // Verdict for one unfixed element
  always_comb begin
    coef_x = JW'(coef_sel_r);
    lim    = u_r + $signed({{(JW-TOL_W){1'b0}}, tol});
    if (!coef_sel_r[COEF_W-1]) begin
      if (u_r < 0)          verd = VERD_CONFLICT;
      else if (coef_x > lim) verd = VERD_FIX0;
      else                  verd = VERD_NONE;
    end else begin
      if (coef_x > lim)     verd = VERD_CONFLICT;
      else if (u_r < 0)     verd = VERD_FIX1;
      else                  verd = VERD_NONE;
    end
    row_conflict = $signed(job.act) > ACT_W'($signed(job.rhs));
  end

  // Walker datapath
  always_ff @(posedge clk) begin
    if (i_clr) i_r <= '0;
    else if (i_inc) i_r <= i_r + IDX_W'(1);

    if (do_load_cur) begin
      cur_var_r <= rd_q.var_idx;
      k_r       <= '0;
      excl_r    <= '0;
      found_r   <= 1'b0;
    end else if (do_scan) begin
      k_r <= k_r + IDX_W'(1);
      if (rd_q.var_idx == cur_var_r) begin
        excl_r <= excl_r + contrib($signed(rd_q.coef), rd_q.fixed, rd_q.value);
        if (!found_r) begin
          coef_sel_r <= $signed(rd_q.coef);
          found_r    <= 1'b1;
        end
      end
    end

    if (do_calc) u_r <= JW'($signed(job.rhs)) - (JW'($signed(job.act)) - JW'(excl_r));

    if (do_emit) begin
      out_var_r  <= cur_var_r;
      out_verd_r <= verd;
      out_row_r  <= 1'b0;
      out_last_r <= (em_r + CNT_W'(1)) == job.unf;
    end else if (do_row) begin
      out_var_r  <= '0;
      out_verd_r <= row_conflict ? VERD_CONFLICT : VERD_NONE;
      out_row_r  <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      em_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (do_emit || do_row) out_valid_r <= 1'b1;
      else if (out_tready)   out_valid_r <= 1'b0;
      if (i_clr)        em_r <= '0;
      else if (do_emit) em_r <= em_r + CNT_W'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_VAR_W-2){1'b0}}, out_verd_r, OUT_VAR_W'(out_var_r)};
  assign out_tuser  = out_row_r;
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/binary_row_bound_propagation.sv */
// Bound propagation for one row of a 0-1 constraint sum(a*x) <= rhs, Q16.16 coefficients.
// Row elements load at one beat per cycle, unless the input stalls, into one of two
// memory banks; the beat with tlast carries rhs and closes the row. A walker then reads
// the stored row through one memory read port, element by element, and for each unfixed
// element scans the whole row to sum the minimum activity of all elements sharing its
// variable. An all-fixed row gives one whole-row verdict. The next row loads into the
// other bank meanwhile; the input stalls only while two finished rows wait for the
// walker. Elements beyond 64 in a row are dropped. Verdict codes: 0 fix at zero,
// 1 fix at one, 2 no implication, 3 conflict. The tolerance register (reset 1) is
// written through the cfg port, which is always ready.
module binary_row_bound_propagation
  import brbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TOL_W-1:0]       cfg_data,   // tolerance
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [11:0] var_index, [43:12] coefficient, [44] lower_bound, [45] upper_bound,
  // [77:46] rhs, [79:78] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,   // last_element
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] out_var_index, [13:12] verdict
  output logic                   out_tuser,  // [0] row_verdict
  output logic                   out_tlast   // last_result
);

  logic [TOL_W-1:0] tol_r;
  logic             job_push, job_pop, job_valid, job_full;
  job_t             push_job, head_job;
  mem_wr_t          wr;

  // Tolerance register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_W'(1);
    else if (cfg_valid) tol_r <= cfg_data;
  end

  brbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (push_job),
    .wr        (wr)
  );

  brbp_job_fifo u_jobs (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head       (head_job),
    .full       (job_full)
  );

  brbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .job_valid  (job_valid),
    .job        (head_job),
    .job_pop    (job_pop),
    .tol        (tol_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A whole-row verdict is always the only, hence last, result of its row
  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("row verdict without last flag");

  // A whole-row verdict never fixes a variable and names variable 0
  a_row_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[13:12] == VERD_NONE || out_tdata[13:12] == VERD_CONFLICT) &&
      out_tdata[11:0] == '0)
    else $error("bad whole-row verdict");

  // Closing a row always leaves a queued row for the walker
  a_row_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> job_valid)
    else $error("closed row not queued");

endmodule
